/* rtl/iirl_pkg.sv */
// Shared types, codes and sizes for the indexed insert/remove list.
`default_nettype none

package iirl_pkg;

    localparam int DEPTH      = 256;
    localparam int ITEM_WIDTH = 32;

    // Fixed port widths.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 9;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;

    // Position of an entry and the fill count (which can reach DEPTH itself).
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Read tree: cell outputs are OR-ed in groups, then the groups are OR-ed.
    localparam int GROUP  = 16;
    localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      pos;
        logic [ITEM_WIDTH-1:0] data;
    } cell_ctrl_t;

    typedef struct packed {
        logic stage1;
        logic stage2;
    } tree_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REDUCE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* rtl/indexed_insert_remove_list.sv */
// Top level of the indexed insert/remove list: command decode, cell row and read path.
`default_nettype none

// An ordered list of DEPTH entries addressed by position, held in a row of
// register cells. Each command is taken on in_valid/in_ready and answered by
// exactly one result on out_valid/out_ready. One command is in flight at a
// time. The command is decoded in the cycle of its transfer in, and its cell
// control is registered. In the execute state every cell shifts or writes at
// once, and the first stage of the registered OR tree latches the entry chosen
// by a get. In the reduce state the second stage latches, and in the output
// state the result is offered. The result register then holds until it is
// taken, and the next command is accepted in the cycle after that transfer, so
// the block takes no new command before the last result is taken. Entries
// beyond the used count are never read; the count resets to zero.
module indexed_insert_remove_list
    import iirl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [INDEX_W-1:0] index,
    input  wire logic [DATA_W-1:0]  item_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [1:0]         status,
    output logic      [DATA_W-1:0]  item_out,
    output logic      [COUNT_W-1:0] count
);

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    cell_ctrl_t       ctrl_reg,   ctrl_next;
    status_t          status_reg, status_next;
    logic             get_ok_reg, get_ok_next;

    cell_ctrl_t            cell_ctrl;
    tree_ctrl_t            tree_ctrl;
    logic [ITEM_WIDTH-1:0] cell_q  [DEPTH];
    logic [ITEM_WIDTH-1:0] cell_rd [DEPTH];
    logic [ITEM_WIDTH-1:0] rd;

    logic [ITEM_WIDTH-1:0] data_in;
    logic                  full;
    logic                  in_range;
    logic [IDX_W-1:0]      tail_pos;

    assign data_in  = ITEM_WIDTH'(item_in);
    assign full     = (used_count_reg == CNT_W'(DEPTH));
    assign in_range = (CMP_W'(index) < CMP_W'(used_count_reg));
    assign tail_pos = IDX_W'(used_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        used_count_next = used_count_reg;
        ctrl_next       = ctrl_reg;
        status_next     = status_reg;
        get_ok_next     = get_ok_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        tree_ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next     = ST_EXEC;
                    status_next    = STATUS_OK;
                    get_ok_next    = 1'b0;
                    ctrl_next.op   = OP_NONE;
                    ctrl_next.pos  = IDX_W'(index);
                    ctrl_next.data = data_in;
                    case (cmd)
                        CMD_APPEND:
                        begin
                            if (full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                ctrl_next.op    = OP_WRITE;
                                ctrl_next.pos   = tail_pos;
                                used_count_next = used_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_SET:
                        begin
                            if (!in_range)
                                status_next = STATUS_RANGE;
                            else
                                ctrl_next.op = OP_WRITE;
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                                status_next = STATUS_FULL;
                            else if (!in_range)
                            begin
                                // Insert at or past the end is an append.
                                ctrl_next.op    = OP_WRITE;
                                ctrl_next.pos   = tail_pos;
                                used_count_next = used_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ctrl_next.op    = OP_INSERT;
                                used_count_next = used_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_GET:
                        begin
                            if (!in_range)
                                status_next = STATUS_RANGE;
                            else
                                get_ok_next = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            if (!in_range)
                                status_next = STATUS_RANGE;
                            else
                            begin
                                ctrl_next.op    = OP_REMOVE;
                                used_count_next = used_count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                tree_ctrl.stage1 = 1'b1;
                state_next       = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                tree_ctrl.stage2 = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg   <= ctrl_next;
        status_reg <= status_next;
        get_ok_reg <= get_ok_next;
    end

    // Cells only change state during the execute cycle.
    always_comb
    begin
        cell_ctrl = ctrl_reg;
        if (state_reg != ST_EXEC)
            cell_ctrl.op = OP_NONE;
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_q;
        logic [ITEM_WIDTH-1:0] right_q;

        if (k == 0)
        begin : g_first
            assign left_q = '0;
        end
        else
        begin : g_inner_left
            assign left_q = cell_q[k - 1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_q = '0;
        end
        else
        begin : g_inner_right
            assign right_q = cell_q[k + 1];
        end

        iirl_cell u_cell (
            .clk      (clk),
            .cell_pos (IDX_W'(k)),
            .ctrl     (cell_ctrl),
            .left_q   (left_q),
            .right_q  (right_q),
            .q        (cell_q[k]),
            .rd_word  (cell_rd[k])
        );
    end

    iirl_read_tree u_read_tree (
        .clk   (clk),
        .ctrl  (tree_ctrl),
        .words (cell_rd),
        .rd    (rd)
    );

    assign status   = status_reg;
    assign item_out = get_ok_reg ? DATA_W'(rd) : '0;
    assign count    = COUNT_W'(used_count_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(DEPTH))
        else $error("used count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg == STATUS_FULL) |-> full)
        else $error("full reported on a store that is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_out != '0) |-> (status_reg == STATUS_OK))
        else $error("read data returned with an error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_REDUCE) && $stable(used_count_reg))
        else $error("count changed while the read tree was settling");

endmodule

`default_nettype wire

/* rtl/iirl_cell.sv */
// One storage cell of the list: holds one entry and shifts with its neighbors.
`default_nettype none

module iirl_cell
    import iirl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [IDX_W-1:0]      cell_pos,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [ITEM_WIDTH-1:0] left_q,
    input  wire logic [ITEM_WIDTH-1:0] right_q,
    output logic      [ITEM_WIDTH-1:0] q,
    output logic      [ITEM_WIDTH-1:0] rd_word
);

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [ITEM_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_WRITE:
            begin
                if (cell_pos == ctrl.pos)
                    entry_next = ctrl.data;
            end
            OP_INSERT:
            begin
                // Cells above the insert point take the entry from below.
                if (cell_pos > ctrl.pos)
                    entry_next = left_q;
                else if (cell_pos == ctrl.pos)
                    entry_next = ctrl.data;
            end
            OP_REMOVE:
            begin
                if (cell_pos >= ctrl.pos)
                    entry_next = right_q;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q       = entry_reg;
    assign rd_word = (cell_pos == ctrl.pos) ? entry_reg : '0;

endmodule

`default_nettype wire

/* rtl/iirl_read_tree.sv */
// Two-stage registered OR tree that collects the one selected cell entry.
`default_nettype none

module iirl_read_tree
    import iirl_pkg::*;
(
    input  wire logic                  clk,
    input  wire tree_ctrl_t            ctrl,
    input  wire logic [ITEM_WIDTH-1:0] words [DEPTH],
    output logic      [ITEM_WIDTH-1:0] rd
);

    logic [ITEM_WIDTH-1:0] group_reg  [NGROUP];
    logic [ITEM_WIDTH-1:0] group_next [NGROUP];
    logic [ITEM_WIDTH-1:0] rd_reg;
    logic [ITEM_WIDTH-1:0] rd_next;

    // At most one cell drives a nonzero word, so OR acts as the selector.
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < DEPTH)
                    group_next[g] = group_next[g] | words[g * GROUP + j];
            end
        end
    end

    always_comb
    begin
        rd_next = '0;
        for (int g = 0; g < NGROUP; g++)
            rd_next = rd_next | group_reg[g];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage1)
            group_reg <= group_next;
        if (ctrl.stage2)
            rd_reg <= rd_next;
    end

    assign rd = rd_reg;

endmodule

`default_nettype wire
